[hw/rtl/fblp_pkg.sv]
// ----------------------------------------------------------------------------
// fblp_pkg
// Shared constants and types for the framed bit list parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fblp_pkg;

    // Character codes
    localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
    localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;  // first of the control whitespace run
    localparam logic [7:0] CH_CR    = 8'h0D;  // last of the control whitespace run
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int MAP_BITS = 16;

    localparam int BUFFER_LEN_DEF  = 50;
    localparam int TOKEN_COUNT_DEF = 16;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_FEW = 2'd1,
        ST_BAD = 2'd2
    } t_status;

    // Token scan phase, one-hot
    typedef enum logic [3:0] {
        PH_SPACE  = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    // Magnitude seen so far
    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_BIG  = 2'd2
    } t_class;

endpackage

`default_nettype wire

[hw/rtl/fblp_if.sv]
// ----------------------------------------------------------------------------
// fblp_in_if / fblp_out_if
// Valid/ready channels of the framed bit list parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface fblp_in_if;
    logic                         valid;
    logic                         ready;
    logic [fblp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fblp_out_if;
    logic                           valid;
    logic                           ready;
    logic [fblp_pkg::STATUS_W-1:0]  frame_status;
    logic [fblp_pkg::MAP_BITS-1:0]  control_word;
    logic [fblp_pkg::MAP_BITS-1:0]  status_bits;

    modport source (output valid, output frame_status, output control_word,
                    output status_bits, input ready);
    modport sink   (input valid, input frame_status, input control_word,
                    input status_bits, output ready);
endinterface

`default_nettype wire

[hw/rtl/framed_bit_list_parser.sv]
// ----------------------------------------------------------------------------
// framed_bit_list_parser
// Parses '<' ... '>' framed lists of comma-separated decimal tokens into a
// 16-bit control map.
// ----------------------------------------------------------------------------
// Takes one received byte per transfer on i_rx and returns one result on
// o_res for every '>' byte; no other byte gives a result. Each byte goes
// through an input register and the parsing logic, so a byte is taken every
// cycle but in the stall below; the result of a '>' goes to a result register.
// The only stall is a '>' in the input register while the result register
// still holds a result that has not been taken; other bytes keep flowing
// while a result waits. Inside a frame, tokens follow atoi rules (leading
// whitespace, optional sign, digits; the scan ends at any other character);
// empty tokens are skipped, and token k worth 0 or 1 sets bit k of the map
// (k below 16, first TOKEN_COUNT tokens only). Bits are staged per frame and
// merged into status_bits at the '>'; control_word follows only when the
// frame reached TOKEN_COUNT tokens. A frame that did not open with '<' or that
// buffered a NUL byte reports a bad format and changes nothing. After
// BUFFER_LEN-1 buffered characters, bytes other than '<' and '>' are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_bit_list_parser #(
    parameter int BUFFER_LEN  = fblp_pkg::BUFFER_LEN_DEF,   // 4..256
    parameter int TOKEN_COUNT = fblp_pkg::TOKEN_COUNT_DEF   // 1..64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fblp_in_if.sink     i_rx,
    fblp_out_if.source  o_res
);

    localparam int CW = $clog2(BUFFER_LEN);         // holds 0..BUFFER_LEN-1
    localparam int TW = $clog2(TOKEN_COUNT + 1);    // holds 0..TOKEN_COUNT
    localparam int MB = fblp_pkg::MAP_BITS;

    localparam logic [CW-1:0] CC_LAST = CW'(BUFFER_LEN - 1);
    localparam logic [TW-1:0] TC_FULL = TW'(TOKEN_COUNT);

    // ---------------- input register ----------------
    logic                         r_in_valid;
    logic [fblp_pkg::BYTE_W-1:0]  r_in_byte;

    // ---------------- parse state ----------------
    logic                  r_in_frame,   n_in_frame;
    logic [CW-1:0]         r_char_count, n_char_count;
    logic                  r_bad_format, n_bad_format;
    logic [TW-1:0]         r_tok_count,  n_tok_count;
    logic                  r_tok_nonempty, n_tok_nonempty;
    fblp_pkg::t_phase      r_tok_phase,  n_tok_phase;
    logic                  r_tok_neg,    n_tok_neg;
    fblp_pkg::t_class      r_tok_class,  n_tok_class;
    logic [MB-1:0]         r_bit_map,    n_bit_map;
    logic [MB-1:0]         r_ctrl_hold,  n_ctrl_hold;
    logic [MB-1:0]         r_pend_mask,  n_pend_mask;
    logic [MB-1:0]         r_pend_val,   n_pend_val;

    // ---------------- result register ----------------
    logic                  r_out_valid;
    fblp_pkg::t_status     r_status,     n_status;
    logic [MB-1:0]         r_out_ctrl;
    logic [MB-1:0]         r_out_bits;

    logic is_close;
    logic out_free;
    logic advance;

    assign is_close = (r_in_byte == fblp_pkg::CH_CLOSE);
    assign out_free = !r_out_valid || o_res.ready;
    // the byte in the input register moves on unless it is a '>' with no room
    assign advance  = r_in_valid && (!is_close || out_free);
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // ---------------- per-byte parse ----------------
    logic                         c_digit;
    logic                         c_space;
    logic [fblp_pkg::BYTE_W-1:0]  c;
    logic [MB-1:0]                tok_bit;
    logic                         tok_zero;
    logic                         tok_one;

    always_comb begin
        c       = r_in_byte;
        c_digit = (c >= fblp_pkg::CH_ZERO) && (c <= fblp_pkg::CH_NINE);
        c_space = (c == fblp_pkg::CH_SPACE) ||
                  ((c >= fblp_pkg::CH_TAB) && (c <= fblp_pkg::CH_CR));

        n_in_frame     = r_in_frame;
        n_char_count   = r_char_count;
        n_bad_format   = r_bad_format;
        n_tok_count    = r_tok_count;
        n_tok_nonempty = r_tok_nonempty;
        n_tok_phase    = r_tok_phase;
        n_tok_neg      = r_tok_neg;
        n_tok_class    = r_tok_class;
        n_bit_map      = r_bit_map;
        n_ctrl_hold    = r_ctrl_hold;
        n_pend_mask    = r_pend_mask;
        n_pend_val     = r_pend_val;
        n_status       = fblp_pkg::ST_BAD;
        tok_bit        = '0;
        tok_zero       = 1'b0;
        tok_one        = 1'b0;

        if (advance) begin
            if (c == fblp_pkg::CH_OPEN) begin
                // (re)open the frame, drop anything parsed so far
                n_in_frame     = 1'b1;
                n_char_count   = CW'(1);
                n_tok_nonempty = 1'b0;
                n_tok_phase    = fblp_pkg::PH_SPACE;
                n_tok_neg      = 1'b0;
                n_tok_class    = fblp_pkg::CLS_ZERO;
                n_tok_count    = '0;
                n_bad_format   = 1'b0;
                n_pend_mask    = '0;
                n_pend_val     = '0;
            end else if (!is_close) begin
                if (r_char_count < CC_LAST) begin
                    if (r_char_count == '0) begin
                        // first buffered character was not '<'
                        n_in_frame     = 1'b0;
                        n_tok_nonempty = 1'b0;
                        n_tok_phase    = fblp_pkg::PH_SPACE;
                        n_tok_neg      = 1'b0;
                        n_tok_class    = fblp_pkg::CLS_ZERO;
                        n_tok_count    = '0;
                        n_bad_format   = 1'b0;
                        n_pend_mask    = '0;
                        n_pend_val     = '0;
                    end
                    n_char_count = r_char_count + CW'(1);
                    if (c == fblp_pkg::CH_NUL) begin
                        n_bad_format = 1'b1;
                    end
                    if (n_in_frame) begin
                        if (c == fblp_pkg::CH_COMMA) begin
                            // close the current token
                            tok_zero = (n_tok_class == fblp_pkg::CLS_ZERO);
                            tok_one  = (n_tok_class == fblp_pkg::CLS_ONE) && !n_tok_neg;
                            if (n_tok_nonempty && (n_tok_count < TC_FULL)) begin
                                tok_bit = MB'(1) << n_tok_count;
                                if (tok_zero || tok_one) begin
                                    n_pend_mask = n_pend_mask | tok_bit;
                                    n_pend_val  = tok_one ? (n_pend_val | tok_bit)
                                                          : (n_pend_val & ~tok_bit);
                                end
                                n_tok_count = n_tok_count + TW'(1);
                            end
                            n_tok_nonempty = 1'b0;
                            n_tok_phase    = fblp_pkg::PH_SPACE;
                            n_tok_neg      = 1'b0;
                            n_tok_class    = fblp_pkg::CLS_ZERO;
                        end else begin
                            n_tok_nonempty = 1'b1;
                            if (n_tok_phase != fblp_pkg::PH_DONE) begin
                                priority if (c_digit) begin
                                    if (n_tok_class != fblp_pkg::CLS_ZERO) begin
                                        n_tok_class = fblp_pkg::CLS_BIG;
                                    end else if (c == fblp_pkg::CH_ZERO) begin
                                        n_tok_class = fblp_pkg::CLS_ZERO;
                                    end else if (c == fblp_pkg::CH_ONE) begin
                                        n_tok_class = fblp_pkg::CLS_ONE;
                                    end else begin
                                        n_tok_class = fblp_pkg::CLS_BIG;
                                    end
                                    n_tok_phase = fblp_pkg::PH_DIGITS;
                                end else if ((n_tok_phase == fblp_pkg::PH_SPACE)
                                             && c_space) begin
                                    n_tok_phase = fblp_pkg::PH_SPACE;
                                end else if ((n_tok_phase == fblp_pkg::PH_SPACE) &&
                                             ((c == fblp_pkg::CH_PLUS) ||
                                              (c == fblp_pkg::CH_MINUS))) begin
                                    n_tok_neg   = (c == fblp_pkg::CH_MINUS);
                                    n_tok_phase = fblp_pkg::PH_SIGN;
                                end else begin
                                    n_tok_phase = fblp_pkg::PH_DONE;
                                end
                            end
                        end
                    end
                end
            end else begin
                // '>': close the last token, commit, report
                if (r_in_frame && (r_char_count != '0) && !r_bad_format) begin
                    tok_zero = (r_tok_class == fblp_pkg::CLS_ZERO);
                    tok_one  = (r_tok_class == fblp_pkg::CLS_ONE) && !r_tok_neg;
                    if (r_tok_nonempty && (r_tok_count < TC_FULL)) begin
                        tok_bit = MB'(1) << r_tok_count;
                        if (tok_zero || tok_one) begin
                            n_pend_mask = r_pend_mask | tok_bit;
                            n_pend_val  = tok_one ? (r_pend_val | tok_bit)
                                                  : (r_pend_val & ~tok_bit);
                        end
                        n_tok_count = r_tok_count + TW'(1);
                    end
                    n_bit_map = (r_bit_map & ~n_pend_mask) | (n_pend_val & n_pend_mask);
                    if (n_tok_count == TC_FULL) begin
                        n_ctrl_hold = n_bit_map;
                        n_status    = fblp_pkg::ST_OK;
                    end else begin
                        n_status    = fblp_pkg::ST_FEW;
                    end
                end
                n_in_frame     = 1'b0;
                n_char_count   = '0;
                n_tok_nonempty = 1'b0;
                n_tok_phase    = fblp_pkg::PH_SPACE;
                n_tok_neg      = 1'b0;
                n_tok_class    = fblp_pkg::CLS_ZERO;
                n_tok_count    = '0;
                n_bad_format   = 1'b0;
                n_pend_mask    = '0;
                n_pend_val     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame     <= 1'b0;
            r_char_count   <= '0;
            r_bad_format   <= 1'b0;
            r_tok_count    <= '0;
            r_tok_nonempty <= 1'b0;
            r_tok_phase    <= fblp_pkg::PH_SPACE;
            r_tok_neg      <= 1'b0;
            r_tok_class    <= fblp_pkg::CLS_ZERO;
            r_bit_map      <= '0;
            r_ctrl_hold    <= '0;
            r_pend_mask    <= '0;
            r_pend_val     <= '0;
        end else begin
            r_in_frame     <= n_in_frame;
            r_char_count   <= n_char_count;
            r_bad_format   <= n_bad_format;
            r_tok_count    <= n_tok_count;
            r_tok_nonempty <= n_tok_nonempty;
            r_tok_phase    <= n_tok_phase;
            r_tok_neg      <= n_tok_neg;
            r_tok_class    <= n_tok_class;
            r_bit_map      <= n_bit_map;
            r_ctrl_hold    <= n_ctrl_hold;
            r_pend_mask    <= n_pend_mask;
            r_pend_val     <= n_pend_val;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_close) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_close) begin
            r_status   <= n_status;
            r_out_ctrl <= n_ctrl_hold;
            r_out_bits <= n_bit_map;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.frame_status = r_status;
    assign o_res.control_word = r_out_ctrl;
    assign o_res.status_bits  = r_out_bits;

endmodule

`default_nettype wire

[test/tb_framed_bit_list_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_bit_list_parser
// Self-checking bench for the framed bit list parser.
// ----------------------------------------------------------------------------
// A byte queue filled at time zero feeds a bursty driver. Every accepted byte
// goes through a bit-accurate parser model kept in the bench, which queues
// the frame result due at each '>'. The monitor takes results under its own
// stall pattern and compares each field with the oldest queued result.
// Stimulus: a short directed run of corner frames, then random frames that
// are mostly well formed (full 16-token lists with random token content),
// mixed with noise, missing openers, NUL bytes, restarts and overlong frames.
// ----------------------------------------------------------------------------

module tb_framed_bit_list_parser;

    localparam int BUF_LEN      = fblp_pkg::BUFFER_LEN_DEF;
    localparam int TOK_N        = fblp_pkg::TOKEN_COUNT_DEF;
    localparam int BYTES_TARGET = 1050;
    localparam int FRAMES_MIN   = 24;
    localparam int HOLD_LEN     = 400;    // long receiver hold-off, in cycles
    localparam int HOLD_AFTER   = 20;     // results seen before the hold-off
    localparam int DRAIN_CYCLES = 20;     // settle time at the end

    // Byte waiting to be sent; drain makes the driver wait until no result is due
    typedef struct {
        logic [7:0] ch;
        bit         drain;
    } t_tx_byte;

    typedef struct {
        fblp_pkg::t_status  st;
        logic [15:0]        ctrl;
        logic [15:0]        bits;
    } t_frame_result;

    logic i_clk;
    logic i_rst_n;

    fblp_in_if  rx_if ();
    fblp_out_if res_if ();

    framed_bit_list_parser #(
        .BUFFER_LEN  (BUF_LEN),
        .TOKEN_COUNT (TOK_N)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    t_tx_byte      tx_bytes[$];
    t_frame_result results_due[$];

    int mismatch_cnt = 0;
    int results_seen = 0;
    int bytes_made   = 0;
    int frames_made  = 0;
    bit drain_next   = 0;

    // ------------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------------
    bit                 in_frm;
    int                 buf_cnt;
    bit                 bad_fmt;
    int                 tok_cnt;
    bit                 tok_nonempty;
    fblp_pkg::t_phase   tok_phase;
    bit                 tok_neg;
    fblp_pkg::t_class   tok_cls;
    logic [15:0]        map_bits;
    logic [15:0]        ctrl_hold;
    logic [15:0]        stage_mask;      // bits touched by the open frame
    logic [15:0]        stage_val;

    task automatic clear_token();
        tok_nonempty = 0;
        tok_phase    = fblp_pkg::PH_SPACE;
        tok_neg      = 0;
        tok_cls      = fblp_pkg::CLS_ZERO;
    endtask

    task automatic clear_frame();
        clear_token();
        tok_cnt    = 0;
        bad_fmt    = 0;
        stage_mask = '0;
        stage_val  = '0;
    endtask

    // Token ends: stage its bit when it is worth exactly 0 or 1
    task automatic close_token();
        bit is_zero;
        bit is_one;
        if (tok_nonempty && tok_cnt < TOK_N) begin
            is_zero = (tok_cls == fblp_pkg::CLS_ZERO);
            is_one  = (tok_cls == fblp_pkg::CLS_ONE) && !tok_neg;
            if ((is_zero || is_one) && tok_cnt < fblp_pkg::MAP_BITS) begin
                stage_mask[tok_cnt] = 1'b1;
                stage_val[tok_cnt]  = is_one;
            end
            tok_cnt++;
        end
        clear_token();
    endtask

    // atoi-style scan of one character inside a frame
    task automatic scan_char(input logic [7:0] c);
        bit is_digit;
        bit is_blank;
        is_digit = (c >= fblp_pkg::CH_ZERO) && (c <= fblp_pkg::CH_NINE);
        is_blank = (c == fblp_pkg::CH_SPACE) ||
                   (c >= fblp_pkg::CH_TAB && c <= fblp_pkg::CH_CR);
        if (c == fblp_pkg::CH_COMMA) begin
            close_token();
        end else begin
            tok_nonempty = 1;
            if (tok_phase != fblp_pkg::PH_DONE) begin
                if (is_digit) begin
                    if (tok_cls != fblp_pkg::CLS_ZERO ||
                        (c != fblp_pkg::CH_ZERO && c != fblp_pkg::CH_ONE))
                        tok_cls = fblp_pkg::CLS_BIG;
                    else if (c == fblp_pkg::CH_ONE)
                        tok_cls = fblp_pkg::CLS_ONE;
                    tok_phase = fblp_pkg::PH_DIGITS;
                end else if (tok_phase == fblp_pkg::PH_SPACE && is_blank) begin
                    // leading whitespace, keep skipping
                end else if (tok_phase == fblp_pkg::PH_SPACE &&
                             (c == fblp_pkg::CH_PLUS || c == fblp_pkg::CH_MINUS)) begin
                    tok_neg   = (c == fblp_pkg::CH_MINUS);
                    tok_phase = fblp_pkg::PH_SIGN;
                end else begin
                    tok_phase = fblp_pkg::PH_DONE;
                end
            end
        end
    endtask

    // One accepted byte; a '>' queues the frame result it must produce
    task automatic parse_byte(input logic [7:0] c);
        fblp_pkg::t_status st;
        if (c == fblp_pkg::CH_OPEN) begin
            in_frm  = 1;
            buf_cnt = 1;
            clear_frame();
        end else if (c != fblp_pkg::CH_CLOSE) begin
            // past the buffer limit the byte is simply dropped
            if (buf_cnt < BUF_LEN - 1) begin
                if (buf_cnt == 0) begin
                    in_frm = 0;
                    clear_frame();
                end
                buf_cnt++;
                if (c == fblp_pkg::CH_NUL)
                    bad_fmt = 1;
                if (in_frm)
                    scan_char(c);
            end
        end else begin
            if (in_frm && buf_cnt != 0 && !bad_fmt) begin
                close_token();
                map_bits = (map_bits & ~stage_mask) | (stage_val & stage_mask);
                if (tok_cnt == TOK_N) begin
                    ctrl_hold = map_bits;
                    st = fblp_pkg::ST_OK;
                end else begin
                    st = fblp_pkg::ST_FEW;
                end
            end else begin
                st = fblp_pkg::ST_BAD;
            end
            results_due.push_back('{st, ctrl_hold, map_bits});
            in_frm  = 0;
            buf_cnt = 0;
            clear_frame();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] c);
        tx_bytes.push_back('{c, drain_next});
        drain_next = 0;
        bytes_made++;
        if (c == fblp_pkg::CH_CLOSE)
            frames_made++;
    endtask

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        if (r == 5)
            return fblp_pkg::CH_SPACE;
        return fblp_pkg::CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    // One token of random shape; padded adds leading blanks to stretch the frame
    task automatic push_token(input bit padded);
        int sel;
        int n;
        if (padded) begin
            n = $urandom_range(2, 4);
            repeat (n) push_byte(blank_char());
        end
        sel = $urandom_range(0, 15);
        case (sel)
            0, 1, 2: push_byte(fblp_pkg::CH_ZERO);
            3, 4, 5: push_byte(fblp_pkg::CH_ONE);
            6: begin
                push_byte(fblp_pkg::CH_MINUS);        // negative zero
                push_byte(fblp_pkg::CH_ZERO);
            end
            7: begin
                push_byte(fblp_pkg::CH_PLUS);
                push_byte(fblp_pkg::CH_ONE);
            end
            8: begin
                push_byte(fblp_pkg::CH_MINUS);
                push_byte(fblp_pkg::CH_ONE);
            end
            9: begin
                push_byte(blank_char());
                push_byte($urandom_range(0, 1) ? fblp_pkg::CH_ONE : fblp_pkg::CH_ZERO);
            end
            10: push_byte(fblp_pkg::CH_ZERO + 8'($urandom_range(2, 9)));
            11: begin
                // huge value, never 0 or 1
                push_byte(fblp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
                n = $urandom_range(1, 4);
                repeat (n) push_byte(fblp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            12: begin
                push_byte($urandom_range(0, 1) ? fblp_pkg::CH_ONE : fblp_pkg::CH_ZERO);
                push_byte($urandom_range(0, 1) ? fblp_pkg::CH_ONE : fblp_pkg::CH_ZERO);
            end
            13: begin
                // scan stops at trailing junk
                push_byte($urandom_range(0, 1) ? fblp_pkg::CH_ONE : fblp_pkg::CH_ZERO);
                push_byte(letter());
            end
            14: ;                           // empty token
            default: begin
                case ($urandom_range(0, 2))
                    0: push_byte(letter());
                    1: push_byte(fblp_pkg::CH_MINUS);
                    default: begin
                        push_byte(fblp_pkg::CH_PLUS);
                        push_byte(fblp_pkg::CH_MINUS);
                        push_byte(fblp_pkg::CH_ONE);
                    end
                endcase
            end
        endcase
    endtask

    task automatic push_tokens(input int ntok, input bit padded);
        for (int i = 0; i < ntok; i++) begin
            push_token(padded);
            if (i < ntok - 1)
                push_byte(fblp_pkg::CH_COMMA);
        end
    endtask

    task automatic gen_frame();
        int  kind;
        int  r;
        int  ntok;
        int  n;
        bit  padded;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 14) == 0)
            drain_next = 1;
        if (kind < 8) begin
            // noise over the full byte range
            n = $urandom_range(1, 12);
            repeat (n) push_byte(8'($urandom_range(0, 255)));
            push_byte(fblp_pkg::CH_CLOSE);
        end else if (kind < 14) begin
            // missing opener
            push_byte(letter());
            push_tokens(TOK_N, 0);
            push_byte(fblp_pkg::CH_CLOSE);
        end else begin
            push_byte(fblp_pkg::CH_OPEN);
            if (kind < 22) begin
                // restart: partial list thrown away by a second '<'
                push_tokens($urandom_range(1, 6), 0);
                push_byte(fblp_pkg::CH_OPEN);
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                ntok = TOK_N;
            else if (r < 82)
                ntok = $urandom_range(TOK_N + 1, TOK_N + 4);
            else
                ntok = $urandom_range(0, TOK_N - 1);
            padded = ($urandom_range(0, 11) == 0);     // usually overruns the buffer
            push_tokens(ntok, padded);
            if ($urandom_range(0, 4) == 0)
                push_byte(fblp_pkg::CH_COMMA);         // trailing empty token
            if (kind < 26)
                push_byte(fblp_pkg::CH_NUL);
            push_byte(fblp_pkg::CH_CLOSE);
        end
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset, stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;

        in_frm    = 0;
        buf_cnt   = 0;
        map_bits  = '0;
        ctrl_hold = '0;
        clear_frame();

        // Directed corners: lone close, missing opener, empty frame, signs,
        // negative zero, huge value, all-ones byte, NUL inside a frame
        push_byte(fblp_pkg::CH_CLOSE);
        push_str("A>");
        push_str("<>");
        push_str("<-0,+1, 1,99,");
        push_byte(8'hFF);
        push_byte(fblp_pkg::CH_CLOSE);
        push_byte(fblp_pkg::CH_OPEN);
        push_byte(fblp_pkg::CH_NUL);
        push_byte(fblp_pkg::CH_CLOSE);

        // sender waits here until every earlier result is back
        drain_next = 1;
        bytes_made  = 0;
        frames_made = 0;
        while (bytes_made < BYTES_TARGET || frames_made < FRAMES_MIN)
            gen_frame();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        while (tx_bytes.size() != 0 || results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #1600000;
        $display("timeout: %0d bytes and %0d results still pending",
                 tx_bytes.size(), results_due.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of transfers with random gaps in between
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        bit fire;
        if (!i_rst_n) begin
            rx_if.valid   <= 0;
            rx_if.rx_byte <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            fire = rx_if.valid && rx_if.ready;
            if (fire) begin
                parse_byte(rx_if.rx_byte);
                void'(tx_bytes.pop_front());
            end
            if (rx_if.valid && !fire) begin
                // offered byte stays put until it is taken
            end else if (gap_left != 0) begin
                gap_left    <= gap_left - 1;
                rx_if.valid <= 0;
            end else if (tx_bytes.size() == 0
                         || (tx_bytes[0].drain && results_due.size() != 0)) begin
                rx_if.valid <= 0;
            end else begin
                rx_if.valid   <= 1;
                rx_if.rx_byte <= tx_bytes[0].ch;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 48);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left <= 0;
                        9:          gap_left <= $urandom_range(15, 40);
                        default:    gap_left <= $urandom_range(1, 6);
                    endcase
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall pattern, checks against the oldest queued result
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s at result %0d: got %0h, expected %0h",
                 field, results_seen, got, want);
        mismatch_cnt++;
    endtask

    int          hold_cycles;
    bit          hold_done;
    logic [31:0] cyc;

    // One long hold-off so the result slot fills and '>' bytes back up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            hold_done   <= 0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_cycles <= HOLD_LEN;
            hold_done   <= 1;
        end
    end

    always @(posedge i_clk) begin
        t_frame_result want;
        bit            take;
        if (!i_rst_n) begin
            res_if.ready <= 0;
            cyc          <= '0;
        end else begin
            cyc <= cyc + 1;
            if (res_if.valid && res_if.ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result status",
                                    int'(res_if.frame_status), 0);
                end else begin
                    want = results_due.pop_front();
                    if (res_if.frame_status !== want.st)
                        report_mismatch("frame_status", int'(res_if.frame_status),
                                        int'(want.st));
                    if (res_if.control_word !== want.ctrl)
                        report_mismatch("control_word", int'(res_if.control_word),
                                        int'(want.ctrl));
                    if (res_if.status_bits !== want.bits)
                        report_mismatch("status_bits", int'(res_if.status_bits),
                                        int'(want.bits));
                end
                results_seen++;
            end
            // stall mode is picked by cyc[9:8]
            case (cyc[9:8])
                2'd0:    take = 1;
                2'd1:    take = $urandom_range(0, 1);
                2'd2:    take = (cyc[2:0] != 3'd5) && (cyc[2:0] != 3'd6);
                default: take = ($urandom_range(0, 7) == 0);
            endcase
            res_if.ready <= take && (hold_cycles == 0);
        end
    end

endmodule
